### rtl/pid_with_integral_clamp_macros.svh
// assertion macros for the pid controller checker
// expects signals clock and reset in the scope where they are used
`ifndef PID_WITH_INTEGRAL_CLAMP_MACROS_SVH
`define PID_WITH_INTEGRAL_CLAMP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PIDC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pidc assertion failed");

// antecedent implies consequent in the following cycle
`define PIDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pidc assertion failed");

`endif

### rtl/pidc_pkg.sv
// shared widths and codes for the pid controller with integral clamp
// no dependencies
package pidc_pkg;

   localparam int ERROR_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 31;
   localparam int INTEG_W     = 32;
   localparam int DERIV_W     = ERROR_W + 1;
   localparam int DRIVE_W     = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = LIMIT_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INT_LIMIT = 2'd3;

   localparam logic KIND_STEP  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

endpackage

### rtl/pid_with_integral_clamp.sv
// Fixed point PID controller with a clamped integral
// Channels:
//   req_*  request: req_kind (step or clear) and a signed Q8.8 req_error_in
//   rsp_*  result: saturated signed 32-bit rsp_drive, one per request
//   csr_*  register writes: gains p, i, d and the integral limit
// A request is taken at a clock edge with valid high and stall low.
// Stage one updates the integral (add and clamp) and the stored error,
// stage two forms the three gain products, stage three sums, shifts and
// saturates into the result register. rsp_valid rises once a request has
// passed from the stage one register through the stage two register into
// the result register; one request per cycle is sustained while the output
// is not stalled, as the integral add and clamp completes within stage one.
// When rsp_stall is high with rsp_valid set the result holds and the earlier stages keep
// filling; req_stall rises only when all three stages are occupied.
// Reset (synchronous) empties the pipeline, zeroes the integral, the stored
// error and the gains, and sets the integral limit to its maximum.
// The user must write registers only while no request is in flight; the block itself does not enforce this.
module pid_with_integral_clamp #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic signed [pidc_pkg::ERROR_W-1:0]    req_error_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pidc_pkg::DRIVE_W-1:0]    rsp_drive,
   input  logic                                   csr_write,
   input  logic        [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [pidc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pidc_pkg::*;

   localparam int PROD_P_W = GAIN_W + ERROR_W;
   localparam int PROD_I_W = GAIN_W + INTEG_W;
   localparam int PROD_D_W = GAIN_W + DERIV_W;
   localparam int ACC_W    = PROD_I_W + 1;
   localparam int SUM_W    = INTEG_W + 1;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}};

   // configuration
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_p_in;
   logic signed [GAIN_W-1:0]  gain_i_ff, gain_i_in;
   logic signed [GAIN_W-1:0]  gain_d_ff, gain_d_in;
   logic        [LIMIT_W-1:0] limit_ff, limit_in;

   // controller state
   logic signed [INTEG_W-1:0] integral_ff, integral_in;
   logic signed [ERROR_W-1:0] prev_error_ff, prev_error_in;

   // pipeline
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [ERROR_W-1:0] s1_error_ff, s1_error_in;
   logic signed [INTEG_W-1:0] s1_integral_ff, s1_integral_in;
   logic signed [DERIV_W-1:0] s1_deriv_ff, s1_deriv_in;

   logic                       s2_valid_ff, s2_valid_in;
   logic signed [PROD_P_W-1:0] s2_prod_p_ff, s2_prod_p_in;
   logic signed [PROD_I_W-1:0] s2_prod_i_ff, s2_prod_i_in;
   logic signed [PROD_D_W-1:0] s2_prod_d_ff, s2_prod_d_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic out_en, s2_en, s1_en, accept;

   logic signed [SUM_W-1:0] sum_wide, limit_pos, limit_neg, clamped;
   logic signed [ACC_W-1:0] acc, shifted;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign accept    = req_valid && s1_en;
   assign req_stall = !s1_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // register writes
   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      limit_in  = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_GAIN_P:    gain_p_in = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:    gain_i_in = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:    gain_d_in = csr_wdata[GAIN_W-1:0];
            CSR_INT_LIMIT: limit_in  = csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // stage one: integral add and clamp, derivative
   always_comb begin
      sum_wide  = SUM_W'(integral_ff) + SUM_W'(req_error_in);
      limit_pos = SUM_W'({1'b0, limit_ff});
      limit_neg = -limit_pos;
      if (sum_wide > limit_pos) begin
         clamped = limit_pos;
      end else if (sum_wide < limit_neg) begin
         clamped = limit_neg;
      end else begin
         clamped = sum_wide;
      end

      integral_in    = integral_ff;
      prev_error_in  = prev_error_ff;
      s1_valid_in    = s1_valid_ff;
      s1_error_in    = s1_error_ff;
      s1_integral_in = s1_integral_ff;
      s1_deriv_in    = s1_deriv_ff;
      if (s1_en) begin
         s1_valid_in = req_valid;
      end
      if (accept) begin
         if (req_kind == KIND_CLEAR) begin
            integral_in    = '0;
            prev_error_in  = '0;
            s1_error_in    = '0;
            s1_integral_in = '0;
            s1_deriv_in    = '0;
         end else begin
            integral_in    = clamped[INTEG_W-1:0];
            prev_error_in  = req_error_in;
            s1_error_in    = req_error_in;
            s1_integral_in = clamped[INTEG_W-1:0];
            s1_deriv_in    = DERIV_W'(req_error_in) - DERIV_W'(prev_error_ff);
         end
      end
   end

   // stage two: gain products
   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_prod_p_in = s2_prod_p_ff;
      s2_prod_i_in = s2_prod_i_ff;
      s2_prod_d_in = s2_prod_d_ff;
      if (s2_en) begin
         s2_valid_in  = s1_valid_ff;
         s2_prod_p_in = PROD_P_W'(gain_p_ff) * PROD_P_W'(s1_error_ff);
         s2_prod_i_in = PROD_I_W'(gain_i_ff) * PROD_I_W'(s1_integral_ff);
         s2_prod_d_in = PROD_D_W'(gain_d_ff) * PROD_D_W'(s1_deriv_ff);
      end
   end

   // stage three: sum, floor shift, saturate
   always_comb begin
      acc     = ACC_W'(s2_prod_p_ff) + ACC_W'(s2_prod_i_ff) + ACC_W'(s2_prod_d_ff);
      shifted = acc >>> FRAC_BITS;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      if (out_en) begin
         rsp_valid_in = s2_valid_ff;
         if (shifted > SAT_HI) begin
            rsp_drive_in = SAT_HI[DRIVE_W-1:0];
         end else if (shifted < SAT_LO) begin
            rsp_drive_in = SAT_LO[DRIVE_W-1:0];
         end else begin
            rsp_drive_in = shifted[DRIVE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= '0;
         gain_i_ff     <= '0;
         gain_d_ff     <= '0;
         limit_ff      <= LIMIT_RESET;
         integral_ff   <= '0;
         prev_error_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         limit_ff      <= limit_in;
         integral_ff   <= integral_in;
         prev_error_ff <= prev_error_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_error_ff    <= s1_error_in;
      s1_integral_ff <= s1_integral_in;
      s1_deriv_ff    <= s1_deriv_in;
      s2_prod_p_ff   <= s2_prod_p_in;
      s2_prod_i_ff   <= s2_prod_i_in;
      s2_prod_d_ff   <= s2_prod_d_in;
      rsp_drive_ff   <= rsp_drive_in;
   end

endmodule

### rtl/pidc_checker.sv
// port-level checks for the pid controller with integral clamp
// depends on pidc_pkg and pid_with_integral_clamp_macros.svh; bound to the top level
`include "pid_with_integral_clamp_macros.svh"

module pidc_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [pidc_pkg::DRIVE_W-1:0]    rsp_drive
);
   import pidc_pkg::*;

   // empty pipeline straight after reset
   `PIDC_ASSERT_SAME(a_reset_empty, $fell(reset), !rsp_valid && !req_stall)

   // back-pressure only when the result is held
   `PIDC_ASSERT_SAME(a_stall_source, req_stall, rsp_valid && rsp_stall)

   // a held result keeps its value
   `PIDC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive))

   // an accepted request reaches the output via stages two and three while rsp_stall stays low
   `PIDC_ASSERT_NEXT(a_latency, (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall,
      rsp_valid)

endmodule

bind pid_with_integral_clamp pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_drive (rsp_drive)
);
